>>> src/r2fb_pkg.sv
// Shared types, constants and geometry for the rotated 2bpp frame store writer.
`default_nettype none

package r2fb_pkg;

  // Frame store geometry limits.
  localparam int MAX_PANEL_WIDTH  = 128;
  localparam int MAX_PANEL_HEIGHT = 256;
  localparam int ROW_BYTES_MAX    = (MAX_PANEL_WIDTH + 3) / 4;
  localparam int STORE_DEPTH      = ROW_BYTES_MAX * MAX_PANEL_HEIGHT;
  localparam int ADDR_W           = $clog2(STORE_DEPTH);
  localparam int TOTAL_W          = $clog2(STORE_DEPTH + 1);
  localparam int ROWB_W           = $clog2(ROW_BYTES_MAX + 1);
  localparam int MCOL_W           = $clog2(MAX_PANEL_WIDTH);
  localparam int XROW_W           = $clog2(MAX_PANEL_HEIGHT);

  // Field and register widths.
  localparam int OP_W    = 2;
  localparam int POS_W   = 12;
  localparam int COLOR_W = 2;
  localparam int CNT_W   = 4;
  localparam int RADDR_W = 13;
  localparam int PW_W    = 8;
  localparam int PH_W    = 9;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;

  // Clamp values for the configuration registers and blit length.
  localparam logic [PW_W-1:0]  PW_MAX   = PW_W'(MAX_PANEL_WIDTH);
  localparam logic [PH_W-1:0]  PH_MAX   = PH_W'(MAX_PANEL_HEIGHT);
  localparam logic [CNT_W-1:0] BLIT_MAX = CNT_W'(8);

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_BLIT      = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic pix_read;
    logic pix_write;
    logic pix_drop;
    logic clr_step;
    logic rd_issue;
    logic load_result;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pix_done;
    logic pix_in_range;
    logic clr_last;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/rotated_2bpp_framebuffer_writer.sv
// Top level of the rotated 2bpp frame store writer: controller plus datapath.
// Set pixel and blit walk their pixels in ST_PIXEL, with ST_MODIFY for each drawn pixel;
// read passes ST_READ, clear sweeps the store in ST_CLEAR; all then wait in ST_FINISH.
// One item is in the block at a time; the next input
// transfer comes the cycle after the result is loaded. Single-port store: RMW reads, then writes.
// Reset restores panel_width 128 and panel_height 256; store contents undefined until written.
`default_nettype none

module rotated_2bpp_framebuffer_writer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [r2fb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [r2fb_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     op,
  input  wire logic [r2fb_pkg::POS_W-1:0]     pos_x,
  input  wire logic [r2fb_pkg::POS_W-1:0]     pos_y,
  input  wire logic [1:0]                     color,
  input  wire logic [7:0]                     bitmap_byte,
  input  wire logic [r2fb_pkg::CNT_W-1:0]     bit_count,
  input  wire logic [r2fb_pkg::RADDR_W-1:0]   read_address,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          read_data,
  output logic                                status
);
  import r2fb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  // Operation sequencer.
  r2fb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Address math, frame store and result register.
  r2fb_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .color        (color),
    .bitmap_byte  (bitmap_byte),
    .bit_count    (bit_count),
    .read_address (read_address),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .read_data    (read_data),
    .status       (status)
  );

endmodule

`default_nettype wire

>>> src/r2fb_ctrl.sv
// Controller state machine that sequences pixel, blit, clear and read operations.
`default_nettype none

module r2fb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [1:0]           op,
  output logic                      in_ready,
  output r2fb_pkg::dp_cmd_t         cmd,
  input  wire r2fb_pkg::dp_status_t stat
);
  import r2fb_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PIXEL  = 6'b000010,
    ST_MODIFY = 6'b000100,
    ST_CLEAR  = 6'b001000,
    ST_READ   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  op_t    in_op;

  assign in_op    = op_t'(op);
  assign in_ready = (state == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          case (in_op)
            OP_SET_PIXEL: state_next = ST_PIXEL;
            OP_BLIT:      state_next = ST_PIXEL;
            OP_CLEAR:     state_next = ST_CLEAR;
            OP_READ:      state_next = ST_READ;
            default:      state_next = ST_READ;
          endcase
        end
      end
      ST_PIXEL: begin
        // Walk the pixels of the item; each drawn pixel costs a read and a write.
        if (stat.pix_done) begin
          state_next = ST_FINISH;
        end else if (stat.pix_in_range) begin
          cmd.pix_read = 1'b1;
          state_next   = ST_MODIFY;
        end else begin
          cmd.pix_drop = 1'b1;
        end
      end
      ST_MODIFY: begin
        cmd.pix_write = 1'b1;
        state_next    = ST_PIXEL;
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        // Hand the result to the output register once it is free.
        if (!stat.out_busy) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> src/r2fb_datapath.sv
// Datapath: configuration, item registers, address math, frame store and result register.
`default_nettype none

module r2fb_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [r2fb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [r2fb_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic [1:0]                   op,
  input  wire logic [r2fb_pkg::POS_W-1:0]   pos_x,
  input  wire logic [r2fb_pkg::POS_W-1:0]   pos_y,
  input  wire logic [1:0]                   color,
  input  wire logic [7:0]                   bitmap_byte,
  input  wire logic [r2fb_pkg::CNT_W-1:0]   bit_count,
  input  wire logic [r2fb_pkg::RADDR_W-1:0] read_address,
  input  wire r2fb_pkg::dp_cmd_t            cmd,
  output r2fb_pkg::dp_status_t              stat,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        read_data,
  output logic                              status
);
  import r2fb_pkg::*;

  // Configuration registers.
  logic [PW_W-1:0] panel_width;
  logic [PH_W-1:0] panel_height;

  // Derived geometry.
  logic [PW_W-1:0]    w_eff;
  logic [PH_W-1:0]    h_eff;
  logic [ROWB_W-1:0]  row_bytes;
  logic [TOTAL_W-1:0] total;

  // Item registers.
  op_t                op_q;
  logic [POS_W-1:0]   px_q;
  logic [POS_W-1:0]   py_q;
  logic [1:0]         color_q;
  logic [7:0]         bits_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [RADDR_W-1:0] raddr_q;

  // Progress and result state.
  logic [CNT_W-1:0]   bit_idx;
  logic [TOTAL_W-1:0] clr_addr;
  logic               drop_flag;
  logic               rd_ok;

  // Pixel address math.
  logic [POS_W:0]     cur_x;
  logic               x_ok;
  logic               y_ok;
  logic [MCOL_W-1:0]  mcol;
  logic [ADDR_W-1:0]  pix_addr;
  logic [CNT_W-1:0]   n_eff;
  logic               bit_set;
  logic [1:0]         paint;
  logic [2:0]         shift;
  logic [ADDR_W-1:0]  addr_q;
  logic [7:0]         mask_q;
  logic [7:0]         val_q;

  // Frame store.
  logic [7:0]         mem [STORE_DEPTH];
  logic [7:0]         mem_q;
  logic [ADDR_W-1:0]  mem_addr;
  logic [7:0]         mem_wdata;
  logic               mem_we;
  logic               mem_re;
  logic               clr_in;
  logic               rd_in;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PW_MAX;
      panel_height <= PH_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PANEL_WIDTH:  panel_width  <= cfg_data[PW_W-1:0];
        REG_PANEL_HEIGHT: panel_height <= cfg_data[PH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective geometry; the byte count is registered off the multiplier.
  assign w_eff     = (panel_width > PW_MAX) ? PW_MAX : panel_width;
  assign h_eff     = (panel_height > PH_MAX) ? PH_MAX : panel_height;
  assign row_bytes = ROWB_W'(({1'b0, w_eff} + 9'd3) >> 2);

  always_ff @(posedge clk) begin
    total <= TOTAL_W'(row_bytes * h_eff);
  end

  // Item capture on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q    <= op_t'(op);
      px_q    <= pos_x;
      py_q    <= pos_y;
      color_q <= color;
      bits_q  <= bitmap_byte;
      cnt_q   <= bit_count;
      raddr_q <= read_address;
    end
  end

  // Current pixel location and bounds.
  assign cur_x   = {1'b0, px_q} + (POS_W + 1)'(bit_idx);
  assign x_ok    = cur_x < (POS_W + 1)'(h_eff);
  assign y_ok    = py_q < POS_W'(w_eff);
  assign mcol    = w_eff[MCOL_W-1:0] - MCOL_W'(1) - py_q[MCOL_W-1:0];
  assign pix_addr = ADDR_W'(mcol[MCOL_W-1:2])
                  + ADDR_W'(cur_x[XROW_W-1:0] * row_bytes);

  // Blit length; a single pixel write draws exactly one.
  assign n_eff   = (op_q == OP_SET_PIXEL) ? CNT_W'(1)
                 : ((cnt_q > BLIT_MAX) ? BLIT_MAX : cnt_q);
  assign bit_set = bits_q[3'd7 - bit_idx[2:0]];
  assign paint   = (op_q == OP_SET_PIXEL || bit_set) ? color_q : 2'd0;
  assign shift   = {mcol[1:0], 1'b0};

  assign stat.pix_done     = bit_idx >= n_eff;
  assign stat.pix_in_range = x_ok && y_ok;

  // Clear sweep bounds, read address check and output stall.
  assign clr_in         = clr_addr < total;
  assign stat.clr_last  = (TOTAL_W + 1)'(clr_addr) + (TOTAL_W + 1)'(1)
                          >= (TOTAL_W + 1)'(total);
  assign rd_in          = TOTAL_W'(raddr_q) < total;
  assign stat.out_busy  = out_valid && !out_ready;

  // Hold the pixel's byte address and lane while the read is in flight.
  always_ff @(posedge clk) begin
    if (cmd.pix_read) begin
      addr_q <= pix_addr;
      mask_q <= 8'hC0 >> shift;
      val_q  <= {paint, 6'b0} >> shift;
    end
  end

  // Progress counters, the drop flag (dropped pixel or bad read address) and the read flag.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      bit_idx   <= '0;
      clr_addr  <= '0;
      drop_flag <= 1'b0;
      rd_ok     <= 1'b0;
    end else begin
      if (cmd.pix_write || cmd.pix_drop) begin
        bit_idx <= bit_idx + CNT_W'(1);
      end
      if (cmd.pix_drop || (cmd.rd_issue && !rd_in)) begin
        drop_flag <= 1'b1;
      end
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + TOTAL_W'(1);
      end
      if (cmd.rd_issue) begin
        rd_ok <= rd_in;
      end
    end
  end

  // Frame store port selection.
  always_comb begin
    mem_addr  = raddr_q[ADDR_W-1:0];
    mem_wdata = {color_q, color_q, color_q, color_q};
    if (cmd.pix_read) begin
      mem_addr = pix_addr;
    end else if (cmd.pix_write) begin
      mem_addr  = addr_q;
      mem_wdata = (mem_q & ~mask_q) | val_q;
    end else if (cmd.clr_step) begin
      mem_addr = clr_addr[ADDR_W-1:0];
    end
  end

  assign mem_we = cmd.pix_write || (cmd.clr_step && clr_in);
  assign mem_re = cmd.pix_read || (cmd.rd_issue && rd_in);

  // Single-port frame store with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      read_data <= rd_ok ? mem_q : 8'd0;
      status    <= drop_flag;
    end
  end

endmodule

`default_nettype wire

>>> src/r2fb_checker.sv
// Port-level assertions for the frame store writer and the bind that attaches them.
`default_nettype none

module r2fb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data,
  input wire logic       status
);

  // A waiting result holds its value until transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
    else $error("result changed while stalled");

  // Items are worked one at a time: no transfer in the cycle after one.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  // A result never appears in the cycle right after an input transfer.
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A dropped pixel or bad address always comes with zero data.
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> read_data == 8'd0)
    else $error("out-of-range result carries data");

endmodule

bind rotated_2bpp_framebuffer_writer r2fb_checker u_r2fb_checker (.*);

`default_nettype wire
